### hdl/ufbd_pkg.sv
// Shared types and constants for the fractional baud divisor block.
// Used by ufbd_cell, ufbd_chain and uart_fractional_baud_divisor.
package ufbd_pkg;

   localparam int CLK_W    = 32;
   localparam int BAUD_W   = 24;
   localparam int NUM_W    = CLK_W + 1;     // doubled source clock
   localparam int DEN_W    = BAUD_W;
   localparam int IDX_W    = $clog2(NUM_W);
   localparam int LIM_W    = 20;            // (baud/100)*3 < 2^20
   localparam int DIV_W    = 13;
   localparam int FRAC_W   = 5;
   localparam int ACT_W    = 28;
   localparam int STAT_W   = 2;
   localparam int RECIP_W  = 25;
   localparam int RECIP_SH = 31;

   localparam logic [IDX_W-1:0]   LAST_BIT  = IDX_W'(NUM_W - 1);
   localparam logic [CLK_W-1:0]   CLK_RESET = 32'd120000000;
   // ceil(2^31/100): exact quotient for every 24-bit input
   localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
   // Doubled quotient must lie in [32, 8191*32+31]
   localparam logic [NUM_W-1:0]   Q2_MIN    = NUM_W'(32);
   localparam logic [NUM_W-1:0]   Q2_MAX    = NUM_W'(262143);

   localparam logic [STAT_W-1:0]  STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0]  STATUS_DIV   = 2'd1;
   localparam logic [STAT_W-1:0]  STATUS_FRAC  = 2'd2;
   localparam logic [STAT_W-1:0]  STATUS_ERROR = 2'd3;

   // One slot of the divider chain
   typedef struct packed {
      logic              valid;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
      logic [DEN_W-1:0]  rem;
      logic [NUM_W-1:0]  quo;
      logic [NUM_W-1:0]  aux;
      logic [BAUD_W-1:0] baud;
      logic [LIM_W-1:0]  lim;
   } stage_type;

   // Three percent error limit: (baud/100)*3 via reciprocal multiply
   function automatic logic [LIM_W-1:0] error_limit(input logic [BAUD_W-1:0] baud);
      logic [BAUD_W+RECIP_W-1:0] prod;
      logic [LIM_W-1:0]          q;
      prod = {{RECIP_W{1'b0}}, baud} * {{BAUD_W{1'b0}}, RECIP_100};
      q    = LIM_W'(prod >> RECIP_SH);
      return (q << 1) + q;
   endfunction

endpackage

### hdl/uart_fractional_baud_divisor.sv
// Top level: baud divisor calculator built from two division cell chains.
// Depends on ufbd_pkg and ufbd_chain.
//
//  port group   direction  handshake        contents
//  req_         in         valid/ready      requested_baud
//  rsp_         out        valid/ready      status, divisor, fraction, actual_baud
//  csr_         in         write enable     source_clock_hz
//
// One request per cycle while the pipeline advances; each request passes one cell per
// quotient bit in each of the two dividers, then the result register.
// The whole pipeline advances when the result register is empty or taken;
// req_ready follows that, so bubbles in flight do not block new requests.
// Reset clears all valid bits and loads the source clock with 120 MHz.
module uart_fractional_baud_divisor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ufbd_pkg::BAUD_W-1:0]   req_requested_baud,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ufbd_pkg::STAT_W-1:0]   rsp_status,
   output logic [ufbd_pkg::DIV_W-1:0]    rsp_divisor,
   output logic [ufbd_pkg::FRAC_W-1:0]   rsp_fraction,
   output logic [ufbd_pkg::ACT_W-1:0]    rsp_actual_baud,
   input  logic                          csr_write_enable,
   input  logic [ufbd_pkg::CLK_W-1:0]    csr_write_data
);
   import ufbd_pkg::*;

   logic [CLK_W-1:0]  clk_hz_ff;
   logic              advance;
   stage_type         entry, c1_out, mid, c2_out;
   logic [NUM_W-1:0]  q2;
   logic [ACT_W-1:0]  actual;
   logic [ACT_W-1:0]  diff;
   logic              div_bad;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [FRAC_W-1:0] fraction_ff, fraction_in;
   logic [ACT_W-1:0]  actual_ff, actual_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Source clock register
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= CLK_RESET;
      end else if (csr_write_enable) begin
         clk_hz_ff <= csr_write_data;
      end
   end

   // First divider: q2 = floor(2*clk / baud)
   always_comb begin
      entry.valid = req_valid;
      entry.num   = {clk_hz_ff, 1'b0};
      entry.den   = req_requested_baud;
      entry.rem   = '0;
      entry.quo   = '0;
      entry.aux   = '0;
      entry.baud  = req_requested_baud;
      entry.lim   = error_limit(req_requested_baud);
   end

   ufbd_chain u_chain_q2 (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .chain_in  (entry),
      .chain_out (c1_out)
   );

   // Second divider: actual = floor(2*clk / q2), q2 kept alongside
   always_comb begin
      mid     = c1_out;
      mid.den = c1_out.quo[DEN_W-1:0];
      mid.aux = c1_out.quo;
      mid.rem = '0;
      mid.quo = '0;
   end

   ufbd_chain u_chain_act (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .chain_in  (mid),
      .chain_out (c2_out)
   );

   // Result classification
   always_comb begin
      q2      = c2_out.aux;
      actual  = c2_out.quo[ACT_W-1:0];
      div_bad = (c2_out.baud == '0) || (q2 < Q2_MIN) || (q2 > Q2_MAX);
      if (actual > {4'b0, c2_out.baud}) begin
         diff = actual - {4'b0, c2_out.baud};
      end else begin
         diff = {4'b0, c2_out.baud} - actual;
      end
      rsp_valid_in = c2_out.valid;
      if (div_bad) begin
         status_in   = STATUS_DIV;
         divisor_in  = '0;
         fraction_in = '0;
         actual_in   = '0;
      end else begin
         divisor_in  = q2[FRAC_W +: DIV_W];
         fraction_in = q2[FRAC_W-1:0];
         actual_in   = actual;
         if (diff > {8'b0, c2_out.lim}) begin
            status_in = STATUS_ERROR;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         status_ff   <= status_in;
         divisor_ff  <= divisor_in;
         fraction_ff <= fraction_in;
         actual_ff   <= actual_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_divisor     = divisor_ff;
   assign rsp_fraction    = fraction_ff;
   assign rsp_actual_baud = actual_ff;

endmodule

### hdl/ufbd_cell.sv
// One restoring division step: brings down one numerator bit per cycle while enabled.
// Depends on ufbd_pkg.
module ufbd_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic [ufbd_pkg::IDX_W-1:0] bit_idx,
   input  ufbd_pkg::stage_type       stage_in,
   output ufbd_pkg::stage_type       stage_out
);
   import ufbd_pkg::*;

   stage_type        stage_ff, stage_in_w;
   logic [IDX_W-1:0] pos;
   logic [DEN_W:0]   partial, trial;
   logic             take;

   // Shift in the next bit and try subtracting the divisor
   always_comb begin
      pos        = LAST_BIT - bit_idx;
      partial    = {stage_in.rem, stage_in.num[pos]};
      trial      = partial - {1'b0, stage_in.den};
      take       = (partial >= {1'b0, stage_in.den});
      stage_in_w = stage_in;
      stage_in_w.rem = take ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
      stage_in_w.quo[pos] = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (enable) begin
         stage_ff.num  <= stage_in_w.num;
         stage_ff.den  <= stage_in_w.den;
         stage_ff.rem  <= stage_in_w.rem;
         stage_ff.quo  <= stage_in_w.quo;
         stage_ff.aux  <= stage_in_w.aux;
         stage_ff.baud <= stage_in_w.baud;
         stage_ff.lim  <= stage_in_w.lim;
      end
   end

   assign stage_out = stage_ff;

endmodule

### hdl/ufbd_chain.sv
// Full-width divider: a row of division cells, one per numerator bit.
// Depends on ufbd_pkg and ufbd_cell.
module ufbd_chain (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  ufbd_pkg::stage_type chain_in,
   output ufbd_pkg::stage_type chain_out
);
   import ufbd_pkg::*;

   stage_type link [0:NUM_W];

   assign link[0] = chain_in;

   // Cell i resolves quotient bit NUM_W-1-i
   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      ufbd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .bit_idx   (IDX_W'(i)),
         .stage_in  (link[i]),
         .stage_out (link[i+1])
      );
   end

   assign chain_out = link[NUM_W];

endmodule

### tb/tb_uart_fractional_baud_divisor.sv
// Testbench for uart_fractional_baud_divisor: directed table then random baud requests,
// checked against an in-bench divisor predictor. Depends on ufbd_pkg and the RTL top.
module tb_uart_fractional_baud_divisor;
   timeunit 1ns;
   timeprecision 1ps;
   import ufbd_pkg::*;

   localparam int LATENCY   = 67;
   localparam int CYCLE_CAP = 400000;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DIV_W-1:0]  divisor;
      logic [FRAC_W-1:0] fraction;
      logic [ACT_W-1:0]  actual_baud;
   } baud_result_type;

   // directed row: clock setting, request, typed expectation where obvious
   typedef struct {
      logic [CLK_W-1:0]  src_clk;
      logic [BAUD_W-1:0] baud;
      bit                typed;
      baud_result_type   want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BAUD_W-1:0] req_requested_baud = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [DIV_W-1:0] rsp_divisor;
   logic [FRAC_W-1:0] rsp_fraction;
   logic [ACT_W-1:0] rsp_actual_baud;
   logic csr_write_enable = 1'b0;
   logic [CLK_W-1:0] csr_write_data = '0;

   logic [CLK_W-1:0] src_clk_hz;
   baud_result_type  pending_rates[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               calm = 1'b0;     // no idling on either side
   bit               hold_req = 1'b0; // asks the receiver for one long stall
   bit               hold_seen = 1'b0;
   int               hold_off = 0;    // long receiver stall, in cycles

   uart_fractional_baud_divisor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_requested_baud(req_requested_baud),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_divisor(rsp_divisor),
      .rsp_fraction(rsp_fraction), .rsp_actual_baud(rsp_actual_baud),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // divisor, fraction and resulting rate for one request
   function automatic baud_result_type divide_baud(logic [CLK_W-1:0] clk_hz,
                                                   logic [BAUD_W-1:0] baud);
      baud_result_type r;
      logic [63:0] dv, fr, act, diff, lim;
      r = '0;
      if (baud == 0) begin
         r.status = STATUS_DIV;
         return r;
      end
      dv = 64'(clk_hz) / (64'(baud) * 16);
      if (dv == 0 || dv > 64'h1FFF) begin
         r.status = STATUS_DIV;
         return r;
      end
      fr = (64'(clk_hz) * 2) / 64'(baud) - 32 * dv;
      if (fr > 64'h1F) begin
         r.status = STATUS_FRAC;
         r.divisor = dv[DIV_W-1:0];
         return r;
      end
      act = (64'(clk_hz) * 2) / (32 * dv + fr);
      diff = (act > baud) ? act - baud : 64'(baud) - act;
      lim = (64'(baud) / 100) * 3;
      r.status = (diff > lim) ? STATUS_ERROR : STATUS_OK;
      r.divisor = dv[DIV_W-1:0];
      r.fraction = fr[FRAC_W-1:0];
      r.actual_baud = act[ACT_W-1:0];
      return r;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_off <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 29);
      end
   end

   // result check on each transfer
   always @(posedge clock) begin
      baud_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_divisor, rsp_fraction, rsp_actual_baud};
         if (pending_rates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %p", got);
         end else begin
            want = pending_rates.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // one request transfer; prediction queued at acceptance
   task automatic send_baud(logic [BAUD_W-1:0] baud, bit typed, baud_result_type want);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_requested_baud <= baud;
      do @(posedge clock); while (!req_ready);
      pending_rates.push_back(typed ? want : divide_baud(src_clk_hz, baud));
   endtask

   // drain, then write the clock register while idle
   task automatic set_source_clock(logic [CLK_W-1:0] hz);
      req_valid <= 1'b0;
      while (pending_rates.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= hz;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      src_clk_hz = hz;
   endtask

   // random baud biased towards rates the clock can reach
   function automatic logic [BAUD_W-1:0] pick_baud();
      logic [63:0] top;
      int sel;
      sel = $urandom_range(9);
      top = 64'(src_clk_hz) / 16;
      if (sel == 0) return BAUD_W'($urandom);
      if (sel == 1) return BAUD_W'($urandom_range(0, 3));
      if (top < 1) return BAUD_W'($urandom_range(1, 16));
      if (top > 64'hFFFFFF) top = 64'hFFFFFF;
      return BAUD_W'($urandom_range(1, 32'(top)));
   endfunction

   initial begin
      dir_row_type rows[$];
      logic [CLK_W-1:0] clocks[7];
      baud_result_type none;
      baud_result_type div_err;
      none = '0;
      div_err = '0;
      div_err.status = STATUS_DIV;
      src_clk_hz = CLK_RESET;
      // reset value first, then extremes and common rates
      rows = '{
         '{CLK_RESET, 24'd115200, 1'b0, none},
         '{CLK_RESET, 24'd9600, 1'b0, none},
         '{CLK_RESET, 24'd0, 1'b1, div_err},
         '{CLK_RESET, 24'hFFFFFF, 1'b1, div_err},
         '{CLK_RESET, 24'd1, 1'b1, div_err},
         '{CLK_RESET, 24'd7500000, 1'b0, none},
         '{CLK_RESET, 24'd900, 1'b0, none},
         '{CLK_RESET, 24'd5000000, 1'b0, none},
         '{32'd0, 24'd115200, 1'b1, div_err},
         '{32'd0, 24'd1, 1'b1, div_err},
         '{32'hFFFFFFFF, 24'hFFFFFF, 1'b0, none},
         '{32'hFFFFFFFF, 24'd32768, 1'b0, none},
         '{32'hFFFFFFFF, 24'd1, 1'b1, div_err},
         '{32'd16, 24'd1, 1'b0, none},
         '{32'd31, 24'd1, 1'b0, none},
         '{32'd1, 24'd1, 1'b1, div_err},
         '{32'd48000000, 24'd3000000, 1'b0, none},
         '{32'd48000000, 24'd2900000, 1'b0, none},
         '{32'd48000000, 24'd2100000, 1'b0, none},
         '{32'd48000000, 24'd366, 1'b0, none}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].src_clk != src_clk_hz)
            set_source_clock(rows[i].src_clk);
         send_baud(rows[i].baud, rows[i].typed, rows[i].want);
      end

      // random phases over several clock settings
      clocks = '{32'd120000000, 32'hFFFFFFFF, 32'd1843200, 32'd16,
                 32'd50000000, 32'd0, 32'd120000000};
      foreach (clocks[p]) begin
         set_source_clock(p == 3 ? 32'($urandom) : clocks[p]);
         calm = (p == 1);
         if (p == 2) hold_req = 1'b1;
         repeat (260) send_baud(pick_baud(), 1'b0, none);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (pending_rates.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

### sim.f
hdl/ufbd_pkg.sv
hdl/ufbd_cell.sv
hdl/ufbd_chain.sv
hdl/uart_fractional_baud_divisor.sv
tb/tb_uart_fractional_baud_divisor.sv
